// ----- design/svmdcu_pkg.sv -----
// Package: shared types, request codes, engine states and constants.
`timescale 1ns / 1ps
package svmdcu_pkg;

  localparam int MAX_SAMPLES_DEF = 256;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 9;
  localparam logic [16:0] WEIGHT_ONE = 17'd65536;

  typedef enum logic [1:0] {
    REQ_LOAD_K = 2'd0,
    REQ_LOAD_W = 2'd1,
    REQ_UPDATE = 2'd2,
    REQ_EVAL   = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS = 1'b0,
    CFG_NEG = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_WREAD,
    S_WWAIT,
    S_FIN,
    S_EACC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [7:0]         row_index;
    logic [7:0]         col_index;
    logic signed [15:0] kernel_value;
    logic [16:0]        weight_value;
  } in_item_t;

  typedef struct packed {
    logic [16:0]        new_weight;
    logic [7:0]         updated_index;
    logic signed [47:0] objective;
    logic               is_objective;
  } out_item_t;

  // Classified command handed from the front queue to the engine.
  typedef struct packed {
    req_t        op;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [15:0] kval;
    logic [16:0] wval;
  } cmd_t;

endpackage

// ----- design/svm_dual_coordinate_update_top.sv -----
// Top level: clipped dual coordinate update engine for a two-class kernel classifier.
// Loads are written by the idle engine after leaving the two-entry front queue; they give no result.
// An update walks its kernel row over the N active samples with the one-MAC row walk, then clips the weight.
// An evaluate does one full row walk per sample and sums the objective over all N samples.
// One item is in the engine at a time; the queue and output register decouple both sides.
// Synchronous active-low reset clears control and counts; kernel and weight stores are not cleared.
`timescale 1ns / 1ps
module svm_dual_coordinate_update_top #(
  parameter int MAX_SAMPLES = svmdcu_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  svmdcu_pkg::in_item_t                  in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output svmdcu_pkg::out_item_t                 out_data,
  input  logic                                  cfg_we,
  input  logic [svmdcu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [svmdcu_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import svmdcu_pkg::*;

  logic [8:0] pos_count_r, neg_count_r;
  logic       q_valid, q_ready;
  cmd_t       q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_count_r <= '0;
      neg_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_POS: pos_count_r <= cfg_wdata;
        CFG_NEG: neg_count_r <= cfg_wdata;
        default: pos_count_r <= pos_count_r;
      endcase
    end
  end

  svmdcu_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  svmdcu_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .pos_count(pos_count_r), .neg_count(neg_count_r),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule

// ----- design/svmdcu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module svmdcu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/svmdcu_front.sv -----
// Front end: accepts items, drops out-of-range ones, clips weights, two-entry queue.
`timescale 1ns / 1ps
module svmdcu_front #(
  parameter int MAX_SAMPLES = svmdcu_pkg::MAX_SAMPLES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  svmdcu_pkg::in_item_t in_data,
  output logic                 q_valid,
  input  logic                 q_ready,
  output svmdcu_pkg::cmd_t     q_cmd
);
  import svmdcu_pkg::*;

  cmd_t       slot_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  logic       keep, push, pop;
  logic       row_ok, col_ok;
  cmd_t       cmd_c;

  assign row_ok = 32'(in_data.row_index) < MAX_SAMPLES;
  assign col_ok = 32'(in_data.col_index) < MAX_SAMPLES;

  always_comb begin
    cmd_c.op   = req_t'(in_data.req_type);
    cmd_c.row  = in_data.row_index;
    cmd_c.col  = in_data.col_index;
    cmd_c.kval = in_data.kernel_value;
    cmd_c.wval = (in_data.weight_value > WEIGHT_ONE) ? WEIGHT_ONE : in_data.weight_value;
    unique case (cmd_c.op)
      REQ_LOAD_K: keep = row_ok && col_ok;
      REQ_LOAD_W: keep = row_ok;
      REQ_UPDATE: keep = row_ok;
      REQ_EVAL:   keep = 1'b1;
      default:    keep = 1'b0;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_c;
    end
  end

endmodule

// ----- design/svmdcu_back.sv -----
// Back end: kernel and weight stores, row multiply-accumulate walk, update and objective.
`timescale 1ns / 1ps
module svmdcu_back #(
  parameter int MAX_SAMPLES = svmdcu_pkg::MAX_SAMPLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  svmdcu_pkg::cmd_t      q_cmd,
  input  logic [8:0]            pos_count,
  input  logic [8:0]            neg_count,
  output logic                  out_valid,
  input  logic                  out_ready,
  output svmdcu_pkg::out_item_t out_data
);
  import svmdcu_pkg::*;

  localparam int IDX_W  = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int KA_W   = $clog2(MAX_SAMPLES * MAX_SAMPLES);
  localparam int PROD_W = 34;
  localparam int ACC_W  = PROD_W + IDX_W;
  localparam int Z_W    = ACC_W + 2;
  localparam int T_W    = Z_W + 18;
  localparam int OBJ_W  = 50;
  localparam longint ONE_Q31 = 64'sd2147483648;
  localparam longint TWO_Q31 = 64'sd4294967296;
  localparam longint OBJ_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint OBJ_MIN = -OBJ_MAX - 64'sd1;

  state_t state_r, state_nxt;
  req_t   op_r, op_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [CNT_W-1:0] p_c, g_c, room_c, p_r, n_r;

  logic                    kram_we, wram_we;
  logic [KA_W-1:0]         kram_waddr, kram_raddr;
  logic [IDX_W-1:0]        wram_waddr, wram_raddr;
  logic [16:0]             wram_wdata, wdat;
  logic [15:0]             kdat;

  logic                    issue, clr_acc, lat_zw, do_mul, do_eacc, clr_obj, out_load;
  logic                    v1_r, s1_r, v2_r, s2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [Z_W-1:0]    z_base, z_c, z_r;
  logic [16:0]              w_r, nw_c;
  logic signed [T_W-1:0]    t_r, term_c;
  logic signed [OBJ_W-1:0]  obj_r;
  logic signed [47:0]       obj_sat;
  logic                     pos_j, out_free, last_i, last_j;
  out_item_t                out_r, out_nxt;

  // Counts are cut to the store size, negatives to the room left.
  always_comb begin
    p_c    = (32'(pos_count) < MAX_SAMPLES) ? CNT_W'(pos_count) : CNT_W'(MAX_SAMPLES);
    room_c = CNT_W'(MAX_SAMPLES) - p_c;
    g_c    = (32'(neg_count) < 32'(room_c)) ? CNT_W'(neg_count) : room_c;
  end

  svmdcu_ram #(.WIDTH(16), .DEPTH(MAX_SAMPLES * MAX_SAMPLES)) u_kram (
    .clk(clk), .we(kram_we), .waddr(kram_waddr), .wdata(q_cmd.kval),
    .raddr(kram_raddr), .rdata(kdat)
  );

  svmdcu_ram #(.WIDTH(17), .DEPTH(MAX_SAMPLES)) u_wram (
    .clk(clk), .we(wram_we), .waddr(wram_waddr), .wdata(wram_wdata),
    .raddr(wram_raddr), .rdata(wdat)
  );

  assign kram_waddr = KA_W'(IDX_W'(q_cmd.row)) * KA_W'(MAX_SAMPLES) + KA_W'(IDX_W'(q_cmd.col));
  assign kram_raddr = KA_W'(j_r) * KA_W'(MAX_SAMPLES) + KA_W'(i_r);
  assign pos_j      = CNT_W'(j_r) < p_r;
  assign last_i     = CNT_W'(i_r) == n_r - CNT_W'(1);
  assign last_j     = CNT_W'(j_r) == n_r - CNT_W'(1);
  assign out_free   = !out_valid || out_ready;

  always_comb begin
    z_base = (op_r == REQ_UPDATE) ? (Z_W'(ONE_Q31) + (Z_W'({1'b0, wdat}) <<< 15))
                                  : Z_W'(TWO_Q31);
    z_c    = pos_j ? z_base - Z_W'(acc_r) : z_base + Z_W'(acc_r);
    if (z_r < 0) begin
      nw_c = 17'd0;
    end else if (z_r > Z_W'(ONE_Q31)) begin
      nw_c = WEIGHT_ONE;
    end else begin
      nw_c = 17'((z_r + Z_W'(16384)) >>> 15);
    end
    term_c = (t_r + T_W'(64'sd1073741824)) >>> 31;
    if (obj_r > OBJ_W'(OBJ_MAX)) begin
      obj_sat = 48'(OBJ_MAX);
    end else if (obj_r < OBJ_W'(OBJ_MIN)) begin
      obj_sat = 48'(OBJ_MIN);
    end else begin
      obj_sat = 48'(obj_r);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    q_ready    = 1'b0;
    kram_we    = 1'b0;
    wram_we    = 1'b0;
    wram_waddr = IDX_W'(q_cmd.row);
    wram_wdata = q_cmd.wval;
    wram_raddr = i_r;
    issue      = 1'b0;
    clr_acc    = 1'b0;
    lat_zw     = 1'b0;
    do_mul     = 1'b0;
    do_eacc    = 1'b0;
    clr_obj    = 1'b0;
    out_load   = 1'b0;
    out_nxt    = out_r;
    unique case (state_r)
      S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          unique case (q_cmd.op)
            REQ_LOAD_K: kram_we = 1'b1;
            REQ_LOAD_W: wram_we = 1'b1;
            REQ_UPDATE: begin
              op_nxt    = REQ_UPDATE;
              j_nxt     = IDX_W'(q_cmd.row);
              i_nxt     = '0;
              clr_acc   = 1'b1;
              state_nxt = (n_r == '0) ? S_DRAIN : S_WALK;
            end
            REQ_EVAL: begin
              op_nxt    = REQ_EVAL;
              j_nxt     = '0;
              i_nxt     = '0;
              clr_acc   = 1'b1;
              clr_obj   = 1'b1;
              state_nxt = (n_r == '0) ? S_DONE : S_WALK;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_WALK: begin
        issue = 1'b1;
        if (last_i) begin
          state_nxt = S_DRAIN;
        end else begin
          i_nxt = i_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        if (!v1_r && !v2_r) begin
          state_nxt = S_WREAD;
        end
      end
      S_WREAD: begin
        wram_raddr = j_r;
        state_nxt  = S_WWAIT;
      end
      S_WWAIT: begin
        lat_zw    = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (op_r == REQ_UPDATE) begin
          if (out_free) begin
            wram_we               = 1'b1;
            wram_waddr            = j_r;
            wram_wdata            = nw_c;
            out_load              = 1'b1;
            out_nxt.new_weight    = nw_c;
            out_nxt.updated_index = 8'(j_r);
            out_nxt.objective     = '0;
            out_nxt.is_objective  = 1'b0;
            state_nxt             = S_IDLE;
          end
        end else begin
          do_mul    = 1'b1;
          state_nxt = S_EACC;
        end
      end
      S_EACC: begin
        do_eacc = 1'b1;
        if (last_j) begin
          state_nxt = S_DONE;
        end else begin
          j_nxt     = j_r + IDX_W'(1);
          i_nxt     = '0;
          clr_acc   = 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load              = 1'b1;
          out_nxt.new_weight    = '0;
          out_nxt.updated_index = '0;
          out_nxt.objective     = obj_sat;
          out_nxt.is_objective  = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      op_r      <= REQ_LOAD_K;
      i_r       <= '0;
      j_r       <= '0;
      p_r       <= '0;
      n_r       <= '0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      p_r     <= p_c;
      n_r     <= p_c + g_c;
      v1_r    <= issue;
      v2_r    <= v1_r;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath: RAM read, product, then signed accumulate by label of column.
  always_ff @(posedge clk) begin
    s1_r   <= CNT_W'(i_r) < p_r;
    s2_r   <= s1_r;
    prod_r <= $signed(kdat) * $signed({1'b0, wdat});
    if (clr_acc) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= s2_r ? acc_r + ACC_W'(prod_r) : acc_r - ACC_W'(prod_r);
    end
    if (lat_zw) begin
      z_r <= z_c;
      w_r <= wdat;
    end
    if (do_mul) begin
      t_r <= z_r * $signed({1'b0, w_r});
    end
    if (clr_obj) begin
      obj_r <= '0;
    end else if (do_eacc) begin
      obj_r <= obj_r + OBJ_W'(term_c);
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

  a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> $past(v1_r)) else $error("product stage valid without a read");
  a_clip: assert property (@(posedge clk) disable iff (!rst_n)
    (wram_we && state_r == S_FIN) |-> (wram_wdata <= WEIGHT_ONE))
    else $error("updated weight above one");
  a_walk_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |=> (state_r == S_WALK || state_r == S_DRAIN))
    else $error("row walk left early");
  a_drain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN && (v1_r || v2_r)) |=> state_r == S_DRAIN)
    else $error("drain left with products in flight");

endmodule

// ----- dv/tb_svm_dual_coordinate_update_top.sv -----
// Testbench for the dual coordinate update block: directed table, random phases, predictor.
`timescale 1ns / 1ps
module tb_svm_dual_coordinate_update_top;
  import svmdcu_pkg::*;

  localparam int NS = 256;
  localparam int SETTLE = 40;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam longint ONE_Q31 = 64'sd1 << 31;
  localparam longint OBJ_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint OBJ_MIN = -OBJ_MAX - 1;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor state and the planner's record of which entries hold data.
  logic signed [15:0] kernel_mem [0:NS*NS-1];
  logic [16:0]        weight_mem [0:NS-1];
  bit                 kernel_set [0:NS*NS-1];
  bit                 weight_set [0:NS-1];
  int                 pos_count;
  int                 neg_count;

  out_item_t pending_results[$];
  int        errors = 0;
  int        items_sent = 0;
  int        send_idle_pct = 12;
  int        recv_stall_pct = 46;
  int        quiet_cycles = 0;
  dir_row_t  dir_tab [0:11];

  svm_dual_coordinate_update_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic in_item_t mk(req_t t, int r, int c, logic [15:0] kv, logic [16:0] wv);
    in_item_t it;
    it.req_type = t;
    it.row_index = r[7:0];
    it.col_index = c[7:0];
    it.kernel_value = kv;
    it.weight_value = wv;
    return it;
  endfunction

  function automatic out_item_t weight_result(int nw, int idx);
    out_item_t r = '0;
    r.new_weight = nw[16:0];
    r.updated_index = idx[7:0];
    return r;
  endfunction

  function automatic void active_counts(output int p, output int g);
    p = (pos_count < NS) ? pos_count : NS;
    g = (neg_count < NS - p) ? neg_count : NS - p;
  endfunction

  // Signed Q.31 dot product of kernel row j with the weights.
  function automatic longint row_dot(int j, int p, int g);
    longint acc = 0;
    longint prod;
    for (int i = 0; i < p + g; i++) begin
      prod = longint'(kernel_mem[j*NS+i]) * longint'({15'd0, weight_mem[i]});
      if (i < p) acc += prod;
      else acc -= prod;
    end
    return acc;
  endfunction

  task automatic predict(in_item_t it, bit typed, out_item_t want);
    int p, g, r, c;
    longint lx, z, obj;
    int nw;
    out_item_t res;
    active_counts(p, g);
    r = it.row_index;
    c = it.col_index;
    res = '0;
    case (req_t'(it.req_type))
      REQ_LOAD_K: kernel_mem[r*NS+c] = it.kernel_value;
      REQ_LOAD_W: weight_mem[r] = (it.weight_value > WEIGHT_ONE) ? WEIGHT_ONE : it.weight_value;
      REQ_UPDATE: begin
        lx = row_dot(r, p, g);
        z = ONE_Q31 + longint'({15'd0, weight_mem[r]}) * 32768;
        z += (r < p) ? -lx : lx;
        if (z < 0) nw = 0;
        else if (z > ONE_Q31) nw = 65536;
        else nw = int'((z + 16384) >>> 15);
        weight_mem[r] = nw[16:0];
        res = weight_result(nw, r);
        pending_results.push_back(typed ? want : res);
      end
      default: begin
        obj = 0;
        for (int j = 0; j < p + g; j++) begin
          lx = row_dot(j, p, g);
          z = 2 * ONE_Q31 + ((j < p) ? -lx : lx);
          obj += (z * longint'({15'd0, weight_mem[j]}) + (64'sd1 <<< 30)) >>> 31;
        end
        if (obj > OBJ_MAX) obj = OBJ_MAX;
        if (obj < OBJ_MIN) obj = OBJ_MIN;
        res.objective = obj[47:0];
        res.is_objective = 1'b1;
        pending_results.push_back(typed ? want : res);
      end
    endcase
  endtask

  task automatic send_item(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
    if (items_sent < 550) begin
      send_idle_pct = 12;
      recv_stall_pct = 46;
    end else if (items_sent < 1100) begin
      send_idle_pct = 46;
      recv_stall_pct = 12;
    end else begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predict(it, typed, want);
    items_sent++;
  endtask

  function automatic logic [15:0] rand_kval();
    if ($urandom_range(1)) return 16'($urandom_range(4095)) - 16'd2048;
    return 16'($urandom);
  endfunction

  function automatic logic [16:0] rand_wval();
    case ($urandom_range(3))
      0: return 17'($urandom_range(65536));
      1: return WEIGHT_ONE;
      2: return 17'($urandom_range(131071));
      default: return 17'($urandom_range(2048));
    endcase
  endfunction

  task automatic load_kernel(int r, int c, logic [15:0] kv);
    kernel_set[r*NS+c] = 1'b1;
    send_item(mk(REQ_LOAD_K, r, c, kv, 17'($urandom)));
  endtask

  task automatic load_weight(int r, logic [16:0] wv);
    weight_set[r] = 1'b1;
    send_item(mk(REQ_LOAD_W, r, $urandom_range(255), 16'($urandom), wv));
  endtask

  // Loads whatever an update of row j still lacks, so nothing undefined is read.
  task automatic fill_row(int j, int n);
    for (int i = 0; i < n; i++) begin
      if (!kernel_set[j*NS+i]) load_kernel(j, i, rand_kval());
      if (!weight_set[i]) load_weight(i, rand_wval());
    end
    if (!weight_set[j]) load_weight(j, rand_wval());
  endtask

  task automatic set_counts(int p, int g);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_POS;
    cfg_wdata <= p[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_NEG;
    cfg_wdata <= g[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    pos_count = p;
    neg_count = g;
  endtask

  task automatic run_phase(int p, int g, int count);
    int ap, ag, n, r, j, c;
    set_counts(p, g);
    active_counts(ap, ag);
    n = ap + ag;
    if (n > 16) begin
      // Large sets: few updates of one row, the weights reloaded between them.
      repeat (3) begin
        repeat (4) load_weight($urandom_range(n - 1), rand_wval());
        fill_row(0, n);
        send_item(mk(REQ_UPDATE, 0, $urandom_range(255), 16'($urandom), 17'($urandom)));
      end
      return;
    end
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 25) begin
        j = (n > 0 && r < 20) ? $urandom_range(n - 1) : $urandom_range(255);
        c = (n > 0 && r < 20) ? $urandom_range(n - 1) : $urandom_range(255);
        load_kernel(j, c, rand_kval());
      end else if (r < 42) begin
        load_weight((n > 0 && r < 38) ? $urandom_range(n - 1) : $urandom_range(255),
                    rand_wval());
      end else if (r < 82) begin
        j = (n > 0 && $urandom_range(3) != 0) ? $urandom_range(n - 1) : $urandom_range(255);
        fill_row(j, n);
        send_item(mk(REQ_UPDATE, j, $urandom_range(255), 16'($urandom), 17'($urandom)));
      end else if (r < 90) begin
        for (int k = 0; k < n; k++) fill_row(k, n);
        send_item(mk(REQ_EVAL, $urandom_range(255), $urandom_range(255),
                     16'($urandom), 17'($urandom)));
      end else if (r < 95) begin
        load_kernel($urandom_range(255), $urandom_range(255), 16'($urandom));
      end else begin
        load_weight($urandom_range(255), 17'($urandom));
      end
    end
  endtask

  // Result checker and receiver stalls.
  always @(posedge clk) begin
    if (rst_n) begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with none expected: %p", $time, out_data);
          errors++;
        end else begin
          out_item_t e;
          e = pending_results.pop_front();
          if (out_data.new_weight !== e.new_weight) begin
            $display("%0t: new_weight expected %0d actual %0d",
                     $time, e.new_weight, out_data.new_weight);
            errors++;
          end
          if (out_data.updated_index !== e.updated_index) begin
            $display("%0t: updated_index expected %0d actual %0d",
                     $time, e.updated_index, out_data.updated_index);
            errors++;
          end
          if (out_data.objective !== e.objective) begin
            $display("%0t: objective expected %0d actual %0d",
                     $time, e.objective, out_data.objective);
            errors++;
          end
          if (out_data.is_objective !== e.is_objective) begin
            $display("%0t: is_objective expected %0b actual %0b",
                     $time, e.is_objective, out_data.is_objective);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    out_item_t obj_zero;
    obj_zero = '0;
    obj_zero.is_objective = 1'b1;
    // With both counts zero the dot product is empty, so an update gives one.
    dir_tab[0]  = '{mk(REQ_LOAD_W, 0, 0, 16'd0, 17'h1FFFF), 1'b0, '0};
    dir_tab[1]  = '{mk(REQ_UPDATE, 0, 0, 16'd0, 17'd0), 1'b1, weight_result(65536, 0)};
    dir_tab[2]  = '{mk(REQ_EVAL, 0, 0, 16'd0, 17'd0), 1'b1, obj_zero};
    dir_tab[3]  = '{mk(REQ_LOAD_W, 255, 255, 16'hFFFF, 17'd0), 1'b0, '0};
    dir_tab[4]  = '{mk(REQ_UPDATE, 255, 255, 16'hFFFF, 17'h1FFFF), 1'b1,
                    weight_result(65536, 255)};
    dir_tab[5]  = '{mk(REQ_LOAD_K, 255, 255, 16'h8000, 17'h1FFFF), 1'b0, '0};
    dir_tab[6]  = '{mk(REQ_LOAD_K, 0, 0, 16'h7FFF, 17'd0), 1'b0, '0};
    dir_tab[7]  = '{mk(REQ_LOAD_W, 1, 0, 16'd0, 17'd65536), 1'b0, '0};
    dir_tab[8]  = '{mk(REQ_UPDATE, 1, 0, 16'd0, 17'd0), 1'b1, weight_result(65536, 1)};
    dir_tab[9]  = '{mk(REQ_LOAD_W, 2, 0, 16'd0, 17'd65537), 1'b0, '0};
    dir_tab[10] = '{mk(REQ_UPDATE, 2, 0, 16'd0, 17'd0), 1'b1, weight_result(65536, 2)};
    dir_tab[11] = '{mk(REQ_EVAL, 255, 255, 16'hFFFF, 17'h1FFFF), 1'b1, obj_zero};

    pos_count = 0;
    neg_count = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[k]) begin
      if (dir_tab[k].item.req_type == REQ_LOAD_W)
        weight_set[dir_tab[k].item.row_index] = 1'b1;
      if (dir_tab[k].item.req_type == REQ_LOAD_K)
        kernel_set[dir_tab[k].item.row_index * NS + dir_tab[k].item.col_index] = 1'b1;
      send_item(dir_tab[k].item, dir_tab[k].typed, dir_tab[k].want);
    end

    run_phase(2, 3, 170);
    run_phase(1, 0, 120);
    run_phase(256, 0, 0);
    run_phase(0, 1, 120);
    run_phase(6, 6, 170);
    run_phase(511, 511, 0);
    run_phase(12, 4, 170);
    run_phase(7, 511, 0);
    run_phase(0, 0, 60);
    run_phase(0, 256, 0);
    run_phase(3, 2, 170);
    run_phase(16, 0, 120);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- svm_dual_coordinate_update_top.f -----
design/svmdcu_pkg.sv
design/svmdcu_ram.sv
design/svmdcu_front.sv
design/svmdcu_back.sv
design/svm_dual_coordinate_update_top.sv
dv/tb_svm_dual_coordinate_update_top.sv
